/* rtl/core/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants for the bitmap slot allocator
// Request and result formats, config register indexes, status codes,
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int OFFSET_W = 20;
  localparam int SIZE_W   = 13;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int DIV_STEPS = 20;
  localparam int DIV_CNT_W = 5;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 20'hFFFFF;
  localparam logic [7:0]          MSB_BIT    = 8'b1000_0000;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  localparam logic CFG_OBJECT_SIZE = 1'b0;
  localparam logic CFG_SLOT_COUNT  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic                mode;
    logic [OFFSET_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] block_offset;
    logic [SIZE_W-1:0]   block_bytes;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_MUL,
    ST_A_FIN,
    ST_F_DIV,
    ST_F_CHK,
    ST_F_RD,
    ST_F_WR
  } state_t;

  typedef struct packed {
    logic                clear;
    logic                load;
    logic                grp_next;
    logic                take;
    logic                mul;
    logic                alloc_wr;
    logic                div_step;
    logic                free_sel;
    logic                free_wr;
    logic                fail;
    logic [STATUS_W-1:0] fail_code;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mode;
    logic zero_size;
    logic found;
    logic more;
    logic fits;
    logic div_last;
    logic in_range;
  } sts_t;

endpackage

/* rtl/core/bsa_dpath.sv */
// ----------------------------------------------------------------------------
// bsa_dpath: datapath of the bitmap slot allocator
// Holds the config registers, the used-bit map as a memory of 8-bit groups,
// the group scanner, the offset multiplier, the restoring divider and the
// result register.
// ----------------------------------------------------------------------------
module bsa_dpath #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [bsa_pkg::SIZE_W-1:0] cfg_data,
  input  bsa_pkg::req_t         in_req,
  input  bsa_pkg::cmd_t         cmd,
  output bsa_pkg::sts_t         sts,
  output logic                  out_valid,
  output bsa_pkg::res_t         out_res
);
  import bsa_pkg::*;

  // A partial last group still gets its own map entry.
  localparam int GROUPS = (MAX_SLOTS + 7) / 8;
  localparam int AW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int DEPTH  = 2 ** AW;
  localparam int SW     = $clog2(MAX_SLOTS) + 1;
  localparam int CW     = (SW > COUNT_W) ? SW : COUNT_W;
  localparam int PW     = CW + SIZE_W;

  logic [SIZE_W-1:0]    size_r;
  logic [COUNT_W-1:0]   count_r;
  logic [7:0]           mem [DEPTH];
  logic [7:0]           rdata_r;
  logic [AW-1:0]        clr_r;
  logic [AW-1:0]        grp_r;
  logic [CW-1:0]        slot_r;
  logic [7:0]           word_r;
  logic [PW-1:0]        prod_r;
  logic [OFFSET_W-1:0]  quo_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 out_valid_r;
  res_t                 out_res_r;

  logic [CW-1:0]        cnt;
  logic [7:0]           vmask;
  logic [7:0]           free_bits;
  logic                 found;
  logic [2:0]           kbit;
  logic [SIZE_W:0]      trial;
  logic                 ge;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [7:0]           mem_wdata;

  // Usable slots: the configured count, limited by the bitmap size.
  assign cnt = (CW'(count_r) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_RESET;
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OBJECT_SIZE: size_r  <= cfg_data;
        CFG_SLOT_COUNT:  count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // First free slot in the current group, most significant bit first.
  always_comb begin
    vmask     = '0;
    found     = 1'b0;
    kbit      = '0;
    for (int j = 0; j < 8; j++) begin
      vmask[j] = (CW'({grp_r, 3'(7 - j)}) < cnt);
    end
    free_bits = ~rdata_r & vmask;
    for (int j = 0; j < 8; j++) begin
      if (free_bits[j]) begin
        found = 1'b1;
        kbit  = 3'(7 - j);
      end
    end
  end

  assign trial = {rem_r, quo_r[OFFSET_W-1]};
  assign ge    = (trial >= {1'b0, size_r});

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = grp_r;
    mem_wdata = '0;
    if (cmd.clear) begin
      mem_we   = 1'b1;
      mem_addr = clr_r;
    end else if (cmd.alloc_wr) begin
      mem_we    = 1'b1;
      mem_wdata = word_r;
    end else if (cmd.free_wr) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_r & ~(MSB_BIT >> quo_r[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[grp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      grp_r     <= '0;
      quo_r     <= in_req.free_offset;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      if (cmd.grp_next) begin
        grp_r <= grp_r + AW'(1);
      end
      if (cmd.free_sel) begin
        grp_r <= quo_r[AW+2:3];
      end
      if (cmd.div_step) begin
        rem_r     <= ge ? SIZE_W'(trial - {1'b0, size_r}) : trial[SIZE_W-1:0];
        quo_r     <= {quo_r[OFFSET_W-2:0], ge};
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
    end
    if (cmd.take) begin
      slot_r <= CW'({grp_r, kbit});
      word_r <= rdata_r | (MSB_BIT >> kbit);
    end
    if (cmd.mul) begin
      prod_r <= PW'(slot_r) * PW'(size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.alloc_wr | cmd.free_wr | cmd.fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_wr) begin
      out_res_r.status       <= STAT_DONE;
      out_res_r.block_offset <= prod_r[OFFSET_W-1:0];
      out_res_r.block_bytes  <= size_r;
    end else if (cmd.free_wr) begin
      out_res_r.status       <= STAT_DONE;
      out_res_r.block_offset <= '0;
      out_res_r.block_bytes  <= '0;
    end else if (cmd.fail) begin
      out_res_r.status       <= cmd.fail_code;
      out_res_r.block_offset <= '0;
      out_res_r.block_bytes  <= '0;
    end
  end

  assign sts.clr_last  = (clr_r == AW'(GROUPS - 1));
  assign sts.mode      = in_req.mode;
  assign sts.zero_size = (size_r == '0);
  assign sts.found     = found;
  assign sts.more      = (CW'({grp_r, 3'b000}) + CW'(8)) < cnt;
  assign sts.fits      = (prod_r <= PW'(OFFSET_MAX));
  assign sts.div_last  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.in_range  = (quo_r < OFFSET_W'(cnt));

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_alloc_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wr |-> prod_r <= PW'(OFFSET_MAX))
    else $error("slot marked used although its offset does not fit");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.free_wr |-> quo_r < OFFSET_W'(cnt))
    else $error("slot freed beyond capacity");

  a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> found)
    else $error("slot taken from a group with no free usable bit");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.alloc_wr, cmd.free_wr}))
    else $error("conflicting bitmap writes");

endmodule

/* rtl/core/bsa_ctrl.sv */
// ----------------------------------------------------------------------------
// bsa_ctrl: controller of the bitmap slot allocator
// Sequences the clearing pass after reset, the group scan of an allocate
// request and the divide, check and bit clear of a free request.
// ----------------------------------------------------------------------------
module bsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bsa_pkg::sts_t sts,
  output bsa_pkg::cmd_t cmd,
  output logic          busy
);
  import bsa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.zero_size) begin
            // No object can be addressed with a zero object size.
            cmd.fail      = 1'b1;
            cmd.fail_code = sts.mode ? STAT_RANGE : STAT_FULL;
          end else if (sts.mode) begin
            state_nxt = ST_F_DIV;
          end else begin
            state_nxt = ST_A_RD;
          end
        end
      end
      ST_A_RD: begin
        state_nxt = ST_A_CHK;
      end
      ST_A_CHK: begin
        if (sts.found) begin
          cmd.take  = 1'b1;
          state_nxt = ST_A_MUL;
        end else if (sts.more) begin
          cmd.grp_next = 1'b1;
          state_nxt    = ST_A_RD;
        end else begin
          cmd.fail      = 1'b1;
          cmd.fail_code = STAT_FULL;
          state_nxt     = ST_IDLE;
        end
      end
      ST_A_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_A_FIN;
      end
      ST_A_FIN: begin
        // The first free slot whose offset overflows means every later one does too.
        if (sts.fits) begin
          cmd.alloc_wr = 1'b1;
        end else begin
          cmd.fail      = 1'b1;
          cmd.fail_code = STAT_FULL;
        end
        state_nxt = ST_IDLE;
      end
      ST_F_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        if (sts.in_range) begin
          cmd.free_sel = 1'b1;
          state_nxt    = ST_F_RD;
        end else begin
          cmd.fail      = 1'b1;
          cmd.fail_code = STAT_RANGE;
          state_nxt     = ST_IDLE;
        end
      end
      ST_F_RD: begin
        state_nxt = ST_F_WR;
      end
      ST_F_WR: begin
        cmd.free_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> cmd.load)
    else $error("accepted request not loaded");

  a_no_resp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !(cmd.fail || cmd.alloc_wr || cmd.free_wr))
    else $error("result issued during clearing pass");

  a_div_to_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_F_DIV && sts.div_last) |=> state_r == ST_F_CHK)
    else $error("divider finish not followed by range check");

endmodule

/* rtl/core/bitmap_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_unit: first-fit fixed-size object pool allocator
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// After reset, busy stays high while the used-bit map is cleared one group
// of eight slots per cycle; config writes are taken at any time. A request
// is accepted when start is high and busy is low, and its result appears on
// out_res for one cycle with out_valid high; the receiver must take it then.
// An allocate reads the map one group of eight at a time, scanning at most
// 32 groups at the default size, and gives the pool-full result when the
// scan runs out of usable slots. A free runs a 20-step restoring division
// of the offset by the object size and gives the range result when the
// offset is out of range. A request with a zero object size is answered in
// the cycle after acceptance. busy falls in the result cycle.
module bitmap_slot_allocator_unit #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bsa_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       start,
  input  bsa_pkg::req_t              in_req,
  output logic                       busy,
  output logic                       out_valid,
  output bsa_pkg::res_t              out_res
);
  import bsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bsa_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
